/* rtl/tcgw_pkg.sv */
package tcgw_pkg;

	localparam int GLYPH_LINES = 16;
	localparam int LINE_W      = $clog2(GLYPH_LINES);
	localparam int FONT_GLYPHS = 95;
	localparam int GLYPH_W     = $clog2(FONT_GLYPHS);

	localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(GLYPH_LINES - 1);

	localparam logic [7:0] CODE_BACKSPACE  = 8'd8;
	localparam logic [7:0] CODE_NEWLINE    = 8'd10;
	localparam logic [7:0] CODE_RETURN     = 8'd13;
	localparam logic [7:0] CODE_SPACE      = 8'd32;
	localparam logic [7:0] CODE_QUESTION   = 8'd63;
	localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
	localparam logic [7:0] LAST_PRINTABLE  = 8'd126;

	localparam logic [1:0] REG_COLUMNS = 2'd0;
	localparam logic [1:0] REG_ROWS    = 2'd1;

	localparam logic [7:0] COLUMNS_RESET = 8'd80;
	localparam logic [5:0] ROWS_RESET    = 6'd30;

	// One drawing job handed from the front to the back.
	typedef struct packed {
		logic [GLYPH_W-1:0] glyph;
		logic [6:0]         column;
		logic [5:0]         row;
	} cmd_t;

	// Each entry holds the sixteen scan lines of one glyph, top line in the high byte.
	localparam logic [127:0] FONT_ROM [FONT_GLYPHS] = '{
		128'h00000000000000000000000000000000,
		128'h00183C3C3C1818001818000000000000,
		128'h006C6C6C000000000000000000000000,
		128'h00006C6CFE6CFE6C6C00000000000000,
		128'h18187EC0C07C0606FC18180000000000,
		128'h000000C6CC183060C686000000000000,
		128'h00386C6C3876DCCCCC76000000000000,
		128'h00181818000000000000000000000000,
		128'h00183060606060603018000000000000,
		128'h00180C06060606060C18000000000000,
		128'h0000663CFF3C66000000000000000000,
		128'h0000181818FF18181800000000000000,
		128'h00000000000000000018181830000000,
		128'h000000000000FE000000000000000000,
		128'h00000000000000000018180000000000,
		128'h000000060C183060C000000000000000,
		128'h007CC6C6CED6E6C6C67C000000000000,
		128'h0018381818181818187E000000000000,
		128'h007CC6060C183060C0FE000000000000,
		128'h007CC606063C0606C67C000000000000,
		128'h000C1C3C6CCCFE0C0C1E000000000000,
		128'h00FEC0C0C0FC0606C67C000000000000,
		128'h003860C0C0FCC6C6C67C000000000000,
		128'h00FEC6060C1830303030000000000000,
		128'h007CC6C6C67CC6C6C67C000000000000,
		128'h007CC6C6C67E06060C78000000000000,
		128'h00000018180000001818000000000000,
		128'h00000018180000001818300000000000,
		128'h00060C18306030180C06000000000000,
		128'h0000000000FE0000FE00000000000000,
		128'h006030180C060C183060000000000000,
		128'h007CC6060C1818001818000000000000,
		128'h007CC6C6DEDEDCC0C07C000000000000,
		128'h0010386CC6C6FEC6C6C6000000000000,
		128'h00FCC6C6C6FCC6C6C6FC000000000000,
		128'h007CC6C0C0C0C0C0C67C000000000000,
		128'h00FCC6C6C6C6C6C6C6FC000000000000,
		128'h00FEC0C0C0F8C0C0C0FE000000000000,
		128'h00FEC0C0C0F8C0C0C0C0000000000000,
		128'h007CC6C0C0CEC6C6C67C000000000000,
		128'h00C6C6C6C6FEC6C6C6C6000000000000,
		128'h003C181818181818183C000000000000,
		128'h001E0C0C0C0C0CCCCC78000000000000,
		128'h00E6C6CCD8F0D8CCC6E6000000000000,
		128'h00C0C0C0C0C0C0C0C6FE000000000000,
		128'h00C6EEFEFED6C6C6C6C6000000000000,
		128'h00C6E6F6FEDECEC6C6C6000000000000,
		128'h007CC6C6C6C6C6C6C67C000000000000,
		128'h00FCC6C6C6FCC0C0C0C0000000000000,
		128'h007CC6C6C6C6C6D6DE7C060000000000,
		128'h00FCC6C6C6FCD8CCC6C6000000000000,
		128'h007CC6C0C07C0606C67C000000000000,
		128'h00FFDB9918181818183C000000000000,
		128'h00C6C6C6C6C6C6C6C67C000000000000,
		128'h00C6C6C6C6C6C66C3810000000000000,
		128'h00C6C6C6C6D6D6FE6C6C000000000000,
		128'h00C6C66C38386CC6C6C6000000000000,
		128'h00C3C3663C181818183C000000000000,
		128'h00FEC68C183060C2C6FE000000000000,
		128'h003C303030303030303C000000000000,
		128'h000000C06030180C0600000000000000,
		128'h003C0C0C0C0C0C0C0C3C000000000000,
		128'h0010386CC60000000000000000000000,
		128'h00000000000000000000FF0000000000,
		128'h00303018000000000000000000000000,
		128'h00000000780C7CCCCC76000000000000,
		128'h00E060607C666666667C000000000000,
		128'h000000007CC6C0C0C67C000000000000,
		128'h001C0C0C7CCCCCCCCC76000000000000,
		128'h000000007CC6FEC0C67C000000000000,
		128'h00386C6060F8606060F0000000000000,
		128'h0000000076CCCCCC7C0CCC7800000000,
		128'h00E060606C76666666E6000000000000,
		128'h0018180038181818183C000000000000,
		128'h000606000E0606060666663C00000000,
		128'h00E06060666C786C66E6000000000000,
		128'h0038181818181818183C000000000000,
		128'h00000000ECFED6D6D6C6000000000000,
		128'h00000000DC6666666666000000000000,
		128'h000000007CC6C6C6C67C000000000000,
		128'h00000000DC6666667C6060F000000000,
		128'h0000000076CCCCCC7C0C0C1E00000000,
		128'h00000000DC76666060F0000000000000,
		128'h000000007CC6700CC67C000000000000,
		128'h00103030FC303030361C000000000000,
		128'h00000000CCCCCCCCCC76000000000000,
		128'h00000000C3C3663C1818000000000000,
		128'h00000000C6C6D6D6D66C000000000000,
		128'h00000000C66C38386CC6000000000000,
		128'h00000000C6C6C6C67E060C7800000000,
		128'h00000000FECC183066FE000000000000,
		128'h000E181818701818180E000000000000,
		128'h00181818180018181818000000000000,
		128'h00701818180E18181870000000000000,
		128'h0076DC00000000000000000000000000
	};

	function automatic logic [7:0] font_row(input logic [GLYPH_W-1:0] glyph,
	                                        input logic [LINE_W-1:0] line);
		logic [127:0] bits;
		bits = FONT_ROM[glyph];
		return bits[127 - 8 * int'(line) -: 8];
	endfunction

endpackage

/* rtl/tcgw_front.sv */
module tcgw_front import tcgw_pkg::*; #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS    = 48
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_code,
	input  logic [7:0] columns_in_use,
	input  logic [5:0] rows_in_use,
	input  logic       enq_full,
	output logic       enq,
	output cmd_t       enq_cmd
);

	localparam int CW = $clog2(MAX_COLUMNS + 1);
	localparam int RW = $clog2(MAX_ROWS + 1);

	logic [CW-1:0] col_q, col_next, col_draw, col_inc, eff_cols;
	logic [RW-1:0] row_q, row_next, row_inc, eff_rows;
	logic          accept, draw, do_clamp, in_screen;
	logic [GLYPH_W-1:0] glyph;

	always_comb begin
		if (columns_in_use == 8'd0) begin
			eff_cols = CW'(1);
		end else if (32'(columns_in_use) > MAX_COLUMNS) begin
			eff_cols = CW'(MAX_COLUMNS);
		end else begin
			eff_cols = CW'(columns_in_use);
		end
		if (rows_in_use == 6'd0) begin
			eff_rows = RW'(1);
		end else if (32'(rows_in_use) > MAX_ROWS) begin
			eff_rows = RW'(MAX_ROWS);
		end else begin
			eff_rows = RW'(rows_in_use);
		end
	end

	always_comb begin
		col_inc  = col_q + CW'(1);
		row_inc  = row_q + RW'(1);
		col_next = col_q;
		row_next = row_q;
		col_draw = col_q;
		draw     = 1'b0;
		do_clamp = 1'b1;
		glyph    = '0;
		unique case (char_code)
			CODE_NEWLINE: begin
				col_next = '0;
				row_next = row_inc;
			end
			CODE_RETURN: begin
				col_next = '0;
			end
			CODE_BACKSPACE: begin
				// The space is drawn at the cell the cursor lands on.
				if (col_q != '0) begin
					col_next = col_q - CW'(1);
				end
				col_draw = col_next;
				draw     = 1'b1;
				do_clamp = 1'b0;
				glyph    = GLYPH_W'(CODE_SPACE - FIRST_PRINTABLE);
			end
			default: begin
				draw = 1'b1;
				if (char_code >= FIRST_PRINTABLE && char_code <= LAST_PRINTABLE) begin
					glyph = GLYPH_W'(char_code - FIRST_PRINTABLE);
				end else begin
					glyph = GLYPH_W'(CODE_QUESTION - FIRST_PRINTABLE);
				end
				if (col_inc >= eff_cols) begin
					col_next = '0;
					row_next = row_inc;
				end else begin
					col_next = col_inc;
				end
			end
		endcase
		if (do_clamp && row_next >= eff_rows) begin
			row_next = eff_rows - RW'(1);
		end
	end

	assign in_screen = (col_draw < eff_cols) && (row_q < eff_rows);
	assign full      = enq_full;
	assign accept    = push && !enq_full;
	assign enq       = accept && draw && in_screen;

	always_comb begin
		enq_cmd.glyph  = glyph;
		enq_cmd.column = 7'(col_draw);
		enq_cmd.row    = 6'(row_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_next;
			row_q <= row_next;
		end
	end

endmodule

/* rtl/tcgw_cmd_queue.sv */
module tcgw_cmd_queue import tcgw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic enq,
	input  cmd_t enq_cmd,
	output logic enq_full,
	input  logic deq,
	output logic deq_valid,
	output cmd_t deq_cmd
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign enq_full  = count_q == 2'd2;
	assign deq_valid = count_q != 2'd0;
	assign deq_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (enq) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({enq, deq})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= enq_cmd;
		end
	end

endmodule

/* rtl/tcgw_back.sv */
module tcgw_back import tcgw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  cmd_t              q_cmd,
	output logic              q_deq,
	output logic              empty,
	input  logic              pop,
	output logic [6:0]        column,
	output logic [5:0]        row,
	output logic [LINE_W-1:0] glyph_line,
	output logic [7:0]        line_bits,
	output logic              last
);

	cmd_t              cur_q;
	logic              busy_q, out_valid_q;
	logic [LINE_W-1:0] line_q;
	logic              advance, at_last, load;

	// The output word moves on when it is taken or when nothing is waiting there.
	assign advance = !out_valid_q || pop;
	assign at_last = line_q == LAST_LINE;
	assign load    = q_valid && (!busy_q || (advance && at_last));
	assign q_deq   = load;
	assign empty   = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			line_q      <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
			end
			if (load) begin
				busy_q <= 1'b1;
				line_q <= '0;
			end else if (advance && busy_q) begin
				if (at_last) begin
					busy_q <= 1'b0;
				end
				line_q <= line_q + LINE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && busy_q) begin
			column     <= cur_q.column;
			row        <= cur_q.row;
			glyph_line <= line_q;
			line_bits  <= font_row(cur_q.glyph, line_q);
			last       <= at_last;
		end
		if (load) begin
			cur_q <= q_cmd;
		end
	end

endmodule

/* rtl/text_console_glyph_writer.sv */
// Text console glyph writer.
// Character bytes enter through a queue-style port: a word is taken on a clock
// edge where push is high and full is low. Newline, return and backspace move
// the cursor; every other byte, and backspace, draws an 8x16 glyph at the
// cursor when on screen. Each drawn cell gives sixteen result words, one
// scan line each, top first, with last set on the final line; cursor moves
// give no words. Results leave through a queue-style port: a word is shown
// while empty is low and is taken on an edge where pop is high.
// Throughput: one line per cycle while the receiver takes every word, set by
// the line sequencer and its registered font read. Cursor-only bytes are
// taken whenever the command queue is not full, and two drawn characters
// can wait in the command queue while the sequencer is busy.
// When the receiver stalls, the current word holds, the sequencer stops, and
// full rises once the command queue fills.
// The configuration port (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready; index 0 sets the column count, index 1 the row count, others are
// ignored. Reset puts the cursor at the top left, sets 80 columns and 30 rows,
// and empties both queues.
module text_console_glyph_writer import tcgw_pkg::*; #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS    = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        char_code,
	output logic              empty,
	input  logic              pop,
	output logic [6:0]        column,
	output logic [5:0]        row,
	output logic [LINE_W-1:0] glyph_line,
	output logic [7:0]        line_bits,
	output logic              last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data
);

	logic [7:0] columns_q;
	logic [5:0] rows_q;
	logic       enq, enq_full, deq, deq_valid;
	cmd_t       enq_cmd, deq_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLUMNS_RESET;
			rows_q    <= ROWS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COLUMNS: columns_q <= cfg_data;
				REG_ROWS:    rows_q    <= cfg_data[5:0];
				default:     ;
			endcase
		end
	end

	tcgw_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.char_code     (char_code),
		.columns_in_use(columns_q),
		.rows_in_use   (rows_q),
		.enq_full      (enq_full),
		.enq           (enq),
		.enq_cmd       (enq_cmd)
	);

	tcgw_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.enq      (enq),
		.enq_cmd  (enq_cmd),
		.enq_full (enq_full),
		.deq      (deq),
		.deq_valid(deq_valid),
		.deq_cmd  (deq_cmd)
	);

	tcgw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (deq_valid),
		.q_cmd     (deq_cmd),
		.q_deq     (deq),
		.empty     (empty),
		.pop       (pop),
		.column    (column),
		.row       (row),
		.glyph_line(glyph_line),
		.line_bits (line_bits),
		.last      (last)
	);

endmodule

/* dv/tb_top.sv */
module tb_top import tcgw_pkg::*;;

	localparam int MAX_COLS    = 128;
	localparam int MAX_ROWS    = 48;
	localparam int SETTLE      = 16;
	localparam int CYCLE_LIMIT = 600000;

	localparam logic [1:0] REG_SPARE_A = 2'd2;
	localparam logic [1:0] REG_SPARE_B = 2'd3;

	typedef enum logic [2:0] {
		STEP_CHAR,
		STEP_TYPED,
		STEP_COLUMNS,
		STEP_ROWS,
		STEP_SPARE_A,
		STEP_SPARE_B
	} step_op_t;

	typedef struct packed {
		step_op_t   op;
		logic [7:0] value;
		logic       drawn;
		logic [6:0] col;
		logic [5:0] row;
		logic [7:0] shown;
	} script_step_t;

	typedef struct packed {
		logic [6:0]        column;
		logic [5:0]        row;
		logic [LINE_W-1:0] line;
		logic [7:0]        bits;
		logic              last;
	} glyph_word_t;

	// Typed rows carry the cell and glyph that must appear; plain character rows
	// and register rows rely on the cursor tracker below.
	localparam int SCRIPT_LEN = 30;
	localparam script_step_t SCRIPT [SCRIPT_LEN] = '{
		'{STEP_TYPED,   8'h41,          1'b1, 7'd0, 6'd0, 8'h41},
		'{STEP_TYPED,   CODE_BACKSPACE, 1'b1, 7'd0, 6'd0, CODE_SPACE},
		'{STEP_TYPED,   CODE_BACKSPACE, 1'b1, 7'd0, 6'd0, CODE_SPACE},
		'{STEP_TYPED,   8'h00,          1'b1, 7'd0, 6'd0, CODE_QUESTION},
		'{STEP_TYPED,   8'hFF,          1'b1, 7'd1, 6'd0, CODE_QUESTION},
		'{STEP_TYPED,   8'h1F,          1'b1, 7'd2, 6'd0, CODE_QUESTION},
		'{STEP_TYPED,   8'h7F,          1'b1, 7'd3, 6'd0, CODE_QUESTION},
		'{STEP_TYPED,   8'h20,          1'b1, 7'd4, 6'd0, 8'h20},
		'{STEP_TYPED,   8'h7E,          1'b1, 7'd5, 6'd0, 8'h7E},
		'{STEP_TYPED,   CODE_RETURN,    1'b0, 7'd0, 6'd0, 8'h00},
		'{STEP_TYPED,   CODE_NEWLINE,   1'b0, 7'd0, 6'd0, 8'h00},
		'{STEP_TYPED,   8'h80,          1'b1, 7'd0, 6'd1, CODE_QUESTION},
		'{STEP_TYPED,   8'h09,          1'b1, 7'd1, 6'd1, CODE_QUESTION},
		'{STEP_COLUMNS, 8'd1,           1'b0, 7'd0, 6'd0, 8'h00},
		'{STEP_TYPED,   8'h78,          1'b0, 7'd0, 6'd0, 8'h00},
		'{STEP_TYPED,   8'h79,          1'b1, 7'd0, 6'd2, 8'h79},
		'{STEP_ROWS,    8'd1,           1'b0, 7'd0, 6'd0, 8'h00},
		'{STEP_TYPED,   8'h7A,          1'b0, 7'd0, 6'd0, 8'h00},
		'{STEP_TYPED,   8'h23,          1'b1, 7'd0, 6'd0, 8'h23},
		'{STEP_TYPED,   CODE_NEWLINE,   1'b0, 7'd0, 6'd0, 8'h00},
		'{STEP_TYPED,   CODE_BACKSPACE, 1'b1, 7'd0, 6'd0, CODE_SPACE},
		'{STEP_SPARE_A, 8'hFF,          1'b0, 7'd0, 6'd0, 8'h00},
		'{STEP_SPARE_B, 8'h00,          1'b0, 7'd0, 6'd0, 8'h00},
		'{STEP_COLUMNS, 8'hFF,          1'b0, 7'd0, 6'd0, 8'h00},
		'{STEP_ROWS,    8'hFF,          1'b0, 7'd0, 6'd0, 8'h00},
		'{STEP_CHAR,    8'h35,          1'b0, 7'd0, 6'd0, 8'h00},
		'{STEP_COLUMNS, 8'h00,          1'b0, 7'd0, 6'd0, 8'h00},
		'{STEP_CHAR,    CODE_BACKSPACE, 1'b0, 7'd0, 6'd0, 8'h00},
		'{STEP_ROWS,    8'h00,          1'b0, 7'd0, 6'd0, 8'h00},
		'{STEP_CHAR,    8'h40,          1'b0, 7'd0, 6'd0, 8'h00}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [7:0]        char_code = 8'h00;
	logic              empty;
	logic              pop = 1'b0;
	logic [6:0]        column;
	logic [5:0]        row;
	logic [LINE_W-1:0] glyph_line;
	logic [7:0]        line_bits;
	logic              last;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = REG_COLUMNS;
	logic [7:0]        cfg_data = 8'h00;

	// Cursor tracker state and its copy of the screen size registers.
	logic [7:0] columns_reg = COLUMNS_RESET;
	logic [5:0] rows_reg = ROWS_RESET;
	int         cursor_col = 0;
	int         cursor_row = 0;

	glyph_word_t lines_due [$];
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          fail_count = 0;
	int          lines_checked = 0;
	int          chars_sent = 0;
	int          screen_writes = 0;
	int          cycles = 0;

	always #5 clk = ~clk;

	text_console_glyph_writer i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.char_code  (char_code),
		.empty      (empty),
		.pop        (pop),
		.column     (column),
		.row        (row),
		.glyph_line (glyph_line),
		.line_bits  (line_bits),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Sixteen scan lines per printable glyph, top line in the high byte.
	function automatic logic [127:0] glyph_bitmap(input int idx);
		case (idx)
			0:  return 128'h00000000000000000000000000000000;
			1:  return 128'h00183C3C3C1818001818000000000000;
			2:  return 128'h006C6C6C000000000000000000000000;
			3:  return 128'h00006C6CFE6CFE6C6C00000000000000;
			4:  return 128'h18187EC0C07C0606FC18180000000000;
			5:  return 128'h000000C6CC183060C686000000000000;
			6:  return 128'h00386C6C3876DCCCCC76000000000000;
			7:  return 128'h00181818000000000000000000000000;
			8:  return 128'h00183060606060603018000000000000;
			9:  return 128'h00180C06060606060C18000000000000;
			10: return 128'h0000663CFF3C66000000000000000000;
			11: return 128'h0000181818FF18181800000000000000;
			12: return 128'h00000000000000000018181830000000;
			13: return 128'h000000000000FE000000000000000000;
			14: return 128'h00000000000000000018180000000000;
			15: return 128'h000000060C183060C000000000000000;
			16: return 128'h007CC6C6CED6E6C6C67C000000000000;
			17: return 128'h0018381818181818187E000000000000;
			18: return 128'h007CC6060C183060C0FE000000000000;
			19: return 128'h007CC606063C0606C67C000000000000;
			20: return 128'h000C1C3C6CCCFE0C0C1E000000000000;
			21: return 128'h00FEC0C0C0FC0606C67C000000000000;
			22: return 128'h003860C0C0FCC6C6C67C000000000000;
			23: return 128'h00FEC6060C1830303030000000000000;
			24: return 128'h007CC6C6C67CC6C6C67C000000000000;
			25: return 128'h007CC6C6C67E06060C78000000000000;
			26: return 128'h00000018180000001818000000000000;
			27: return 128'h00000018180000001818300000000000;
			28: return 128'h00060C18306030180C06000000000000;
			29: return 128'h0000000000FE0000FE00000000000000;
			30: return 128'h006030180C060C183060000000000000;
			31: return 128'h007CC6060C1818001818000000000000;
			32: return 128'h007CC6C6DEDEDCC0C07C000000000000;
			33: return 128'h0010386CC6C6FEC6C6C6000000000000;
			34: return 128'h00FCC6C6C6FCC6C6C6FC000000000000;
			35: return 128'h007CC6C0C0C0C0C0C67C000000000000;
			36: return 128'h00FCC6C6C6C6C6C6C6FC000000000000;
			37: return 128'h00FEC0C0C0F8C0C0C0FE000000000000;
			38: return 128'h00FEC0C0C0F8C0C0C0C0000000000000;
			39: return 128'h007CC6C0C0CEC6C6C67C000000000000;
			40: return 128'h00C6C6C6C6FEC6C6C6C6000000000000;
			41: return 128'h003C181818181818183C000000000000;
			42: return 128'h001E0C0C0C0C0CCCCC78000000000000;
			43: return 128'h00E6C6CCD8F0D8CCC6E6000000000000;
			44: return 128'h00C0C0C0C0C0C0C0C6FE000000000000;
			45: return 128'h00C6EEFEFED6C6C6C6C6000000000000;
			46: return 128'h00C6E6F6FEDECEC6C6C6000000000000;
			47: return 128'h007CC6C6C6C6C6C6C67C000000000000;
			48: return 128'h00FCC6C6C6FCC0C0C0C0000000000000;
			49: return 128'h007CC6C6C6C6C6D6DE7C060000000000;
			50: return 128'h00FCC6C6C6FCD8CCC6C6000000000000;
			51: return 128'h007CC6C0C07C0606C67C000000000000;
			52: return 128'h00FFDB9918181818183C000000000000;
			53: return 128'h00C6C6C6C6C6C6C6C67C000000000000;
			54: return 128'h00C6C6C6C6C6C66C3810000000000000;
			55: return 128'h00C6C6C6C6D6D6FE6C6C000000000000;
			56: return 128'h00C6C66C38386CC6C6C6000000000000;
			57: return 128'h00C3C3663C181818183C000000000000;
			58: return 128'h00FEC68C183060C2C6FE000000000000;
			59: return 128'h003C303030303030303C000000000000;
			60: return 128'h000000C06030180C0600000000000000;
			61: return 128'h003C0C0C0C0C0C0C0C3C000000000000;
			62: return 128'h0010386CC60000000000000000000000;
			63: return 128'h00000000000000000000FF0000000000;
			64: return 128'h00303018000000000000000000000000;
			65: return 128'h00000000780C7CCCCC76000000000000;
			66: return 128'h00E060607C666666667C000000000000;
			67: return 128'h000000007CC6C0C0C67C000000000000;
			68: return 128'h001C0C0C7CCCCCCCCC76000000000000;
			69: return 128'h000000007CC6FEC0C67C000000000000;
			70: return 128'h00386C6060F8606060F0000000000000;
			71: return 128'h0000000076CCCCCC7C0CCC7800000000;
			72: return 128'h00E060606C76666666E6000000000000;
			73: return 128'h0018180038181818183C000000000000;
			74: return 128'h000606000E0606060666663C00000000;
			75: return 128'h00E06060666C786C66E6000000000000;
			76: return 128'h0038181818181818183C000000000000;
			77: return 128'h00000000ECFED6D6D6C6000000000000;
			78: return 128'h00000000DC6666666666000000000000;
			79: return 128'h000000007CC6C6C6C67C000000000000;
			80: return 128'h00000000DC6666667C6060F000000000;
			81: return 128'h0000000076CCCCCC7C0C0C1E00000000;
			82: return 128'h00000000DC76666060F0000000000000;
			83: return 128'h000000007CC6700CC67C000000000000;
			84: return 128'h00103030FC303030361C000000000000;
			85: return 128'h00000000CCCCCCCCCC76000000000000;
			86: return 128'h00000000C3C3663C1818000000000000;
			87: return 128'h00000000C6C6D6D6D66C000000000000;
			88: return 128'h00000000C66C38386CC6000000000000;
			89: return 128'h00000000C6C6C6C67E060C7800000000;
			90: return 128'h00000000FECC183066FE000000000000;
			91: return 128'h000E181818701818180E000000000000;
			92: return 128'h00181818180018181818000000000000;
			93: return 128'h00701818180E18181870000000000000;
			94: return 128'h0076DC00000000000000000000000000;
			default: return '0;
		endcase
	endfunction

	// Moves the tracked cursor for one character. Returns 1 when a cell is drawn,
	// with its position and the character actually shown.
	function automatic bit advance_cursor(input logic [7:0] code, output logic [6:0] cell_col,
	                                      output logic [5:0] cell_row, output logic [7:0] shown);
		int cols;
		int rows;
		bit drawn;
		cols = (columns_reg == 0) ? 1 : (columns_reg > MAX_COLS) ? MAX_COLS : int'(columns_reg);
		rows = (rows_reg == 0) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
		drawn = 1'b0;
		shown = code;
		if (code == CODE_NEWLINE) begin
			cursor_col = 0;
			cursor_row++;
		end else if (code == CODE_RETURN) begin
			cursor_col = 0;
		end else if (code == CODE_BACKSPACE) begin
			// Backspace erases in place and skips the wrap and the clamp.
			if (cursor_col > 0)
				cursor_col--;
			cell_col = 7'(cursor_col);
			cell_row = 6'(cursor_row);
			shown = CODE_SPACE;
			return cursor_col < cols && cursor_row < rows;
		end else begin
			drawn = cursor_col < cols && cursor_row < rows;
			if (code < FIRST_PRINTABLE || code > LAST_PRINTABLE)
				shown = CODE_QUESTION;
			cell_col = 7'(cursor_col);
			cell_row = 6'(cursor_row);
			cursor_col++;
		end
		if (cursor_col >= cols) begin
			cursor_col = 0;
			cursor_row++;
		end
		if (cursor_row >= rows)
			cursor_row = rows - 1;
		return drawn;
	endfunction

	task automatic queue_cell(input logic [6:0] col, input logic [5:0] rw, input logic [7:0] shown);
		logic [127:0] bitmap;
		glyph_word_t  w;
		bitmap = glyph_bitmap(int'(shown) - int'(FIRST_PRINTABLE));
		for (int j = 0; j < GLYPH_LINES; j++) begin
			w.column = col;
			w.row    = rw;
			w.line   = LINE_W'(j);
			w.bits   = bitmap[127 - 8 * j -: 8];
			w.last   = (j == GLYPH_LINES - 1);
			lines_due.push_back(w);
		end
	endtask

	// Returns at the edge where the character is taken; push stays up so that a
	// following character can go out without a gap.
	task automatic send_char(input logic [7:0] code);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push      <= 1'b1;
		char_code <= code;
		do @(posedge clk); while (full);
		chars_sent++;
	endtask

	task automatic type_char(input logic [7:0] code);
		logic [6:0] c;
		logic [5:0] r;
		logic [7:0] s;
		send_char(code);
		if (advance_cursor(code, c, r, s))
			queue_cell(c, r, s);
	endtask

	// Register writes happen only once every queued line is out and the block
	// has had time to finish any cursor-only characters.
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		push <= 1'b0;
		while (lines_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_COLUMNS: columns_reg = data;
			REG_ROWS:    rows_reg = data[5:0];
			default: ;
		endcase
		screen_writes++;
	endtask

	function automatic logic [7:0] random_code();
		int pick;
		pick = $urandom_range(99);
		if (pick < 68)
			return 8'($urandom_range(LAST_PRINTABLE, FIRST_PRINTABLE));
		else if (pick < 76)
			return CODE_NEWLINE;
		else if (pick < 81)
			return CODE_RETURN;
		else if (pick < 88)
			return CODE_BACKSPACE;
		return 8'($urandom_range(255));
	endfunction

	task automatic set_screen(input int kind);
		case (kind)
			0: begin
				write_reg(REG_COLUMNS, 8'($urandom_range(12, 1)));
				write_reg(REG_ROWS, 8'($urandom_range(6, 1)));
			end
			1: begin
				write_reg(REG_COLUMNS, $urandom_range(1) ? 8'h00 : 8'($urandom_range(255, 129)));
				write_reg(REG_ROWS, $urandom_range(1) ? 8'h00 : 8'($urandom_range(63, 49)));
			end
			2: begin
				write_reg(REG_COLUMNS, 8'($urandom));
				write_reg(REG_ROWS, 8'($urandom));
			end
			default: begin
				// Shrinking under a cursor that sits far out leaves it off screen.
				write_reg(REG_COLUMNS, 8'($urandom_range(4, 1)));
				write_reg(REG_ROWS, 8'($urandom_range(3, 1)));
			end
		endcase
		write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, 8'($urandom));
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		glyph_word_t w;
		if (arst_n && pop && !empty) begin
			if (lines_due.size() == 0) begin
				$display("%0t: unexpected word at column %0d row %0d line %0d",
				         $time, column, row, glyph_line);
				fail_count++;
			end else begin
				w = lines_due.pop_front();
				check_field("column", 8'(w.column), 8'(column));
				check_field("row", 8'(w.row), 8'(row));
				check_field("glyph_line", 8'(w.line), 8'(glyph_line));
				check_field("line_bits", w.bits, line_bits);
				check_field("last", 8'(w.last), 8'(last));
			end
			lines_checked++;
		end
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d words outstanding", $time, lines_due.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		script_step_t st;
		logic [6:0]   c;
		logic [5:0]   r;
		logic [7:0]   s;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 21;
		recv_idle_pct = 86;
		for (int i = 0; i < SCRIPT_LEN; i++) begin
			st = SCRIPT[i];
			case (st.op)
				STEP_CHAR: type_char(st.value);
				STEP_TYPED: begin
					send_char(st.value);
					void'(advance_cursor(st.value, c, r, s));
					if (st.drawn)
						queue_cell(st.col, st.row, st.shown);
				end
				STEP_COLUMNS: write_reg(REG_COLUMNS, st.value);
				STEP_ROWS:    write_reg(REG_ROWS, st.value);
				STEP_SPARE_A: write_reg(REG_SPARE_A, st.value);
				STEP_SPARE_B: write_reg(REG_SPARE_B, st.value);
				default: ;
			endcase
		end

		for (int phase = 0; phase < 2; phase++) begin
			if (phase == 1) begin
				send_idle_pct = 86;
				recv_idle_pct = 21;
			end
			for (int kind = 0; kind < 4; kind++) begin
				set_screen(kind);
				repeat (40) type_char(random_code());
			end
		end

		// Full-size screen with no idling: run one line past the last column,
		// then walk down to the last row and keep pressing against it.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_COLUMNS, 8'(MAX_COLS));
		write_reg(REG_ROWS, 8'(MAX_ROWS));
		repeat (140) type_char(8'($urandom_range(LAST_PRINTABLE, FIRST_PRINTABLE)));
		repeat (50) type_char(CODE_NEWLINE);
		type_char(8'h5A);

		push <= 1'b0;
		while (lines_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Typed %0d characters over %0d register writes; %0d glyph words checked.",
		         chars_sent, screen_writes, lines_checked);
		if (fail_count == 0 && lines_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d failures", fail_count);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
